[sv/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CO2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must hold at every clock edge outside reset
`define CO2_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

[sv/co2cf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// co2cf_pkg
// Shared constants, types and codes of the co2 ppm calibrate and filter block.
// ----------------------------------------------------------------------------
package co2cf_pkg;

  localparam int WindowDefault = 20;

  localparam int CoefW  = 32;
  localparam int AddrW  = 5;
  localparam int TempW  = 7;
  localparam int SwingW = 12;
  localparam int ConcW  = 16;

  localparam int DiffW  = SwingW + 1;
  localparam int TermW  = 25;
  localparam int ProdW  = CoefW + TermW;
  localparam int AccW   = 60;
  localparam int FracW  = 16;

  // dividends stay below 2**DivW, reciprocals are scaled by 2**RecipW
  localparam int DivW   = 23;
  localparam int RecipW = 30;

  localparam int MulSteps  = 6;
  localparam int LiftLimit = 4500;
  localparam int LiftDiv   = 15;
  localparam int LiftBase  = 100;
  localparam int ScaleDiv  = 100;
  localparam int StepLimit = 25;
  localparam int StepDiv   = 20;
  localparam int SatLimit  = 6553600;
  localparam int OutMax    = 65535;

  typedef enum logic [2:0] {
    REG_TEMP    = 3'd0,
    REG_DIFF    = 3'd1,
    REG_TEMP_SQ = 3'd2,
    REG_DIFF_SQ = 3'd3,
    REG_CROSS   = 3'd4,
    REG_OFFSET  = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ABS,
    ST_LIFT_DIV,
    ST_SCALE_DIV,
    ST_RING,
    ST_RING_RD,
    ST_RING_DIV,
    ST_LIMIT,
    ST_LIMIT_DIV,
    ST_SMOOTH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              go;
    logic [DivW-1:0]   dividend;
    logic [RecipW-1:0] recip;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
  } div_rsp_t;

endpackage

[sv/co2cf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// co2cf_div
// Divide by a constant through reciprocal multiplication, shared by every divide step.
// ----------------------------------------------------------------------------
module co2cf_div (
  input  logic                clk,
  input  logic                rst,
  input  co2cf_pkg::div_req_t req,
  output co2cf_pkg::div_rsp_t rsp
);
  import co2cf_pkg::*;

  logic [DivW-1:0]        dvnd;
  logic [RecipW-1:0]      recip;
  logic [DivW+RecipW-1:0] prod;
  logic                   busy;
  logic                   done;

  // operands latched on go, product and done registered on the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        dvnd  <= req.dividend;
        recip <= req.recip;
        busy  <= 1'b1;
      end else if (busy) begin
        prod <= dvnd * recip;
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // quotient is the product scaled back by the reciprocal weight
  assign rsp.done = done;
  assign rsp.quot = prod[DivW+RecipW-1:RecipW];

endmodule

[sv/co2_ppm_calibrate_and_filter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// co2_ppm_calibrate_and_filter_top
// Quadratic calibration, ring average, step limiter and smoother for co2 ppm.
// ----------------------------------------------------------------------------
// One word is processed at a time. The input is held off from acceptance until
// the result register is loaded, which waits while an earlier result is stalled,
// and the next word is taken from the idle state after that. The shared 32x25
// multiplier sums the six polynomial terms; each divide by a constant (by 15,
// by 100, by WINDOW, by 20) is a reciprocal multiply on the shared divider.
// Saturated values skip the calibration divides, small values take the extra
// divide by 15, averaging adds a memory read and a divide, and large steps add
// the limiter divide. No clearing pass runs after reset: the ring is filled
// during warm-up and a running sum of the ring is kept alongside it.
module co2_ppm_calibrate_and_filter_top #(
  parameter int WINDOW = co2cf_pkg::WindowDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [co2cf_pkg::AddrW-1:0]   paddr,
  input  logic [co2cf_pkg::CoefW-1:0]   pwdata,
  output logic [co2cf_pkg::CoefW-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [co2cf_pkg::TempW-1:0]   temperature,
  input  logic [co2cf_pkg::SwingW-1:0]  active_swing,
  input  logic [co2cf_pkg::SwingW-1:0]  reference_swing,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [co2cf_pkg::ConcW-1:0]   concentration,
  output logic                          window_full
);
  import co2cf_pkg::*;

  localparam int IdxW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CntW = $clog2(WINDOW + 1);
  localparam int SumW = $clog2(WINDOW * (OutMax + 1));
  localparam int MulCntW = $clog2(MulSteps + 1);
  localparam int DiffLW = ConcW + 2;

  // reciprocals of the constant divisors
  localparam logic [RecipW-1:0] RecipLift  = RecipW'((64'd1 << RecipW) / LiftDiv + 1);
  localparam logic [RecipW-1:0] RecipScale = RecipW'((64'd1 << RecipW) / ScaleDiv + 1);
  localparam logic [RecipW-1:0] RecipWin   = RecipW'((64'd1 << RecipW) / WINDOW + 1);
  localparam logic [RecipW-1:0] RecipStep  = RecipW'((64'd1 << RecipW) / StepDiv + 1);

  // configuration registers
  logic signed [CoefW-1:0] temp_coef, diff_coef, temp_sq_coef;
  logic signed [CoefW-1:0] diff_sq_coef, cross_coef, offset_term;
  reg_idx_t cfg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coef    <= '0;
      diff_coef    <= '0;
      temp_sq_coef <= '0;
      diff_sq_coef <= '0;
      cross_coef   <= '0;
      offset_term  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TEMP:    temp_coef    <= pwdata;
        REG_DIFF:    diff_coef    <= pwdata;
        REG_TEMP_SQ: temp_sq_coef <= pwdata;
        REG_DIFF_SQ: diff_sq_coef <= pwdata;
        REG_CROSS:   cross_coef   <= pwdata;
        REG_OFFSET:  offset_term  <= pwdata;
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_TEMP:    prdata = temp_coef;
      REG_DIFF:    prdata = diff_coef;
      REG_TEMP_SQ: prdata = temp_sq_coef;
      REG_DIFF_SQ: prdata = diff_sq_coef;
      REG_CROSS:   prdata = cross_coef;
      REG_OFFSET:  prdata = offset_term;
      default:     prdata = '0;
    endcase
  end

  // state
  state_t state, state_next;
  logic   accept;

  // polynomial terms
  logic signed [DiffW-1:0]       y_in;
  logic signed [TempW:0]         x_s;
  logic [2*TempW-1:0]            xx_in;
  logic signed [2*DiffW-1:0]     yy_in;
  logic signed [DiffW+TempW:0]   xy_in;
  logic signed [TermW-1:0]       t_x, t_y, t_xx, t_yy, t_xy;
  logic [MulCntW-1:0]            mul_cnt;
  logic signed [CoefW-1:0]       mul_a;
  logic signed [TermW-1:0]       mul_b;
  logic signed [ProdW-1:0]       prod;
  logic signed [AccW-1:0]        acc;
  logic [AccW-1:0]               abs_val;
  logic [AccW-FracW-1:0]         int_part;

  // ring, limiter and smoother
  logic [ConcW-1:0]  ring_mem [WINDOW];
  logic [ConcW-1:0]  rd_data;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [ConcW-1:0]  mem_wdata;
  logic [IdxW-1:0]   slot_sel;
  logic [IdxW-1:0]   slot;
  logic [CntW-1:0]   fill_index;
  logic              primed;
  logic [SumW-1:0]   ring_sum;
  logic [SumW-1:0]   sum_tmp;
  logic [SumW-1:0]   sum_new;
  logic [ConcW-1:0]  old_val;
  logic [ConcW-1:0]  cal;
  logic [ConcW-1:0]  ring_val;
  logic              full_flag;
  logic signed [ConcW:0]    lim_prev;
  logic signed [DiffLW-1:0] lim_d;
  logic signed [DiffLW-1:0] lim_step;
  logic signed [DiffLW-1:0] lim_sum;
  logic [DiffLW-1:0]        lim_mag;
  logic                     lim_neg;
  logic [ConcW-1:0]         lim_out;
  logic [ConcW-1:0]         sm_prev;
  logic [ConcW:0]           sm_sum;

  div_req_t dreq;
  div_rsp_t drsp;

  co2cf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid & ~in_stall;

  // input terms
  always_comb begin
    x_s   = $signed({1'b0, temperature});
    y_in  = $signed({1'b0, reference_swing}) - $signed({1'b0, active_swing});
    xx_in = temperature * temperature;
    yy_in = y_in * y_in;
    xy_in = x_s * y_in;
  end

  // coefficient and term of the current multiply step
  always_comb begin
    case (mul_cnt)
      MulCntW'(0): begin mul_a = temp_coef;    mul_b = t_x;  end
      MulCntW'(1): begin mul_a = diff_coef;    mul_b = t_y;  end
      MulCntW'(2): begin mul_a = temp_sq_coef; mul_b = t_xx; end
      MulCntW'(3): begin mul_a = diff_sq_coef; mul_b = t_yy; end
      MulCntW'(4): begin mul_a = cross_coef;   mul_b = t_xy; end
      default:     begin mul_a = offset_term;  mul_b = TermW'(1); end
    endcase
  end

  // magnitude and integer part
  always_comb begin
    abs_val  = acc[AccW-1] ? AccW'(-acc) : AccW'(acc);
    int_part = abs_val[AccW-1:FracW];
  end

  // ring slot, sums and limiter arithmetic
  always_comb begin
    slot_sel = (fill_index == CntW'(WINDOW)) ? '0 : fill_index[IdxW-1:0];
    old_val  = primed ? rd_data : '0;
    sum_new  = ring_sum - SumW'(old_val) + SumW'(cal);
    lim_d    = $signed({2'b00, ring_val}) - $signed({lim_prev[ConcW], lim_prev});
    lim_neg  = lim_d[DiffLW-1];
    lim_mag  = lim_neg ? DiffLW'(-lim_d) : DiffLW'(lim_d);
    lim_step = lim_neg ? -$signed(drsp.quot[DiffLW-1:0]) : $signed(drsp.quot[DiffLW-1:0]);
    lim_sum  = $signed({lim_prev[ConcW], lim_prev}) + lim_step;
    sm_sum   = {1'b0, lim_out} + {1'b0, sm_prev};
  end

  // ring memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_index[IdxW-1:0];
    mem_wdata = cal;
    if (state == ST_RING && fill_index < CntW'(WINDOW - 1)) begin
      mem_we = 1'b1;
    end else if (state == ST_RING_DIV && drsp.done) begin
      mem_we    = 1'b1;
      mem_waddr = slot;
      mem_wdata = drsp.quot[ConcW-1:0];
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= ring_mem[slot_sel];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (accept) state_next = ST_MUL;
      ST_MUL:       if (mul_cnt == MulCntW'(MulSteps)) state_next = ST_ABS;
      ST_ABS: begin
        if (int_part < (AccW-FracW)'(LiftLimit)) begin
          state_next = ST_LIFT_DIV;
        end else if (int_part >= (AccW-FracW)'(SatLimit)) begin
          state_next = ST_RING;
        end else begin
          state_next = ST_SCALE_DIV;
        end
      end
      ST_LIFT_DIV:  if (drsp.done) state_next = ST_SCALE_DIV;
      ST_SCALE_DIV: if (drsp.done) state_next = ST_RING;
      ST_RING: begin
        if (fill_index < CntW'(WINDOW - 1)) state_next = ST_LIMIT;
        else state_next = ST_RING_RD;
      end
      ST_RING_RD:   state_next = ST_RING_DIV;
      ST_RING_DIV:  if (drsp.done) state_next = ST_LIMIT;
      ST_LIMIT: begin
        if (lim_d > DiffLW'(StepLimit) || lim_d < -DiffLW'(StepLimit)) begin
          state_next = ST_LIMIT_DIV;
        end else begin
          state_next = ST_SMOOTH;
        end
      end
      ST_LIMIT_DIV: if (drsp.done) state_next = ST_SMOOTH;
      ST_SMOOTH:    state_next = ST_DONE;
      ST_DONE:      if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      dreq.go    <= 1'b0;
      fill_index <= '0;
      primed     <= 1'b0;
      ring_sum   <= '0;
      lim_prev   <= '0;
      sm_prev    <= '0;
      out_valid  <= 1'b0;
      mul_cnt    <= '0;
    end else begin
      dreq.go <= 1'b0;
      if (state == ST_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            t_x     <= {{(TermW-TempW){1'b0}}, temperature};
            t_y     <= {{(TermW-DiffW){y_in[DiffW-1]}}, y_in};
            t_xx    <= {{(TermW-2*TempW){1'b0}}, xx_in};
            t_yy    <= yy_in[TermW-1:0];
            t_xy    <= {{(TermW-DiffW-TempW-1){xy_in[DiffW+TempW]}}, xy_in};
            acc     <= '0;
            mul_cnt <= '0;
          end
        end
        ST_MUL: begin
          if (mul_cnt != MulCntW'(MulSteps)) begin
            prod <= mul_a * mul_b;
          end
          if (mul_cnt != '0) begin
            acc <= acc + {{(AccW-ProdW){prod[ProdW-1]}}, prod};
          end
          mul_cnt <= mul_cnt + 1'b1;
        end
        ST_ABS: begin
          if (int_part < (AccW-FracW)'(LiftLimit)) begin
            dreq.go       <= 1'b1;
            dreq.dividend <= int_part[DivW-1:0];
            dreq.recip    <= RecipLift;
          end else if (int_part >= (AccW-FracW)'(SatLimit)) begin
            cal <= ConcW'(OutMax);
          end else begin
            dreq.go       <= 1'b1;
            dreq.dividend <= int_part[DivW-1:0];
            dreq.recip    <= RecipScale;
          end
        end
        ST_LIFT_DIV: begin
          if (drsp.done) begin
            dreq.go       <= 1'b1;
            dreq.dividend <= drsp.quot + DivW'(LiftBase);
            dreq.recip    <= RecipScale;
          end
        end
        ST_SCALE_DIV: begin
          if (drsp.done) cal <= drsp.quot[ConcW-1:0];
        end
        ST_RING: begin
          if (fill_index < CntW'(WINDOW - 1)) begin
            ring_sum   <= sum_new;
            fill_index <= fill_index + 1'b1;
            ring_val   <= cal;
            full_flag  <= 1'b0;
          end else begin
            slot <= slot_sel;
          end
        end
        ST_RING_RD: begin
          sum_tmp       <= sum_new;
          dreq.go       <= 1'b1;
          dreq.dividend <= DivW'(sum_new);
          dreq.recip    <= RecipWin;
        end
        ST_RING_DIV: begin
          if (drsp.done) begin
            ring_sum   <= sum_tmp - SumW'(cal) + SumW'(drsp.quot[ConcW-1:0]);
            fill_index <= CntW'(slot) + 1'b1;
            primed     <= 1'b1;
            ring_val   <= drsp.quot[ConcW-1:0];
            full_flag  <= 1'b1;
          end
        end
        ST_LIMIT: begin
          if (lim_d > DiffLW'(StepLimit) || lim_d < -DiffLW'(StepLimit)) begin
            dreq.go       <= 1'b1;
            dreq.dividend <= DivW'(lim_mag);
            dreq.recip    <= RecipStep;
          end else begin
            lim_out <= ring_val;
          end
        end
        ST_LIMIT_DIV: begin
          if (drsp.done) lim_out <= lim_sum[ConcW-1:0];
        end
        ST_SMOOTH: begin
          sm_prev  <= lim_out;
          lim_prev <= {1'b0, lim_out};
          ring_val <= sm_sum[ConcW:1];
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            concentration <= ring_val;
            window_full   <= full_flag;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[sv/co2cf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// co2cf_checker
// Port level checks of the co2 ppm block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module co2cf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [co2cf_pkg::ConcW-1:0] concentration,
  input logic                        window_full,
  input logic                        pready
);

  // a taken word keeps the input held off while it is processed
  `CO2_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "input not held off")

  // a result word appears only at the end of processing
  `CO2_ASSERT(a_result_after_work, $rose(out_valid) |-> $past(in_stall), "result out of sequence")

  // a stalled result word stays valid and unchanged
  `CO2_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(concentration) && $stable(window_full)), "stalled word changed")

  `CO2_ALWAYS(a_pready_high, pready, "pready low")

endmodule

bind co2_ppm_calibrate_and_filter_top co2cf_checker u_co2cf_checker (.*);

[bench/tb_co2_ppm_calibrate_and_filter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_co2_ppm_calibrate_and_filter_top
// Self-checking bench for the co2 ppm calibrate and filter block.
// ----------------------------------------------------------------------------
// Words go in through a valid/stall channel with random gaps and come back
// through a randomly stalled output channel. A local predictor tracks the
// polynomial, lift, scaling, ring average, step limiter and smoother state.
// Every result is compared with the oldest prediction. Coefficients are
// rewritten over the APB port between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_co2_ppm_calibrate_and_filter_top;
  import co2cf_pkg::*;

  localparam int Window     = WindowDefault;
  localparam int RegCount   = 6;
  localparam int RegBeyond  = 6;
  localparam int IdleLimit  = 20000;
  localparam int DrainCycles = 200;

  typedef struct {
    logic [ConcW-1:0] conc;
    logic             full;
  } conc_word_t;

  logic                clk;
  logic                rst;
  logic                psel, penable, pwrite;
  logic [AddrW-1:0]    paddr;
  logic [CoefW-1:0]    pwdata;
  logic [CoefW-1:0]    prdata;
  logic                pready;
  logic                in_valid, in_stall;
  logic [TempW-1:0]    temperature;
  logic [SwingW-1:0]   active_swing, reference_swing;
  logic                out_valid, out_stall;
  logic [ConcW-1:0]    concentration;
  logic                window_full;

  // predictor state
  logic signed [CoefW-1:0] coef_shadow [RegCount];
  logic [ConcW-1:0]        ring_shadow [Window];
  int                      fill_shadow;
  int                      limiter_shadow;
  int                      smoother_shadow;

  conc_word_t conc_expected [$];
  int  mismatches;
  int  words_sent;
  int  words_checked;
  int  coef_writes;
  int  idle_cycles;
  bit  no_idle;
  int  stall_left;

  co2_ppm_calibrate_and_filter_top dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .temperature(temperature), .active_swing(active_swing),
    .reference_swing(reference_swing),
    .out_valid(out_valid), .out_stall(out_stall),
    .concentration(concentration), .window_full(window_full)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // signed coefficient of random size: shift 0 spans the full range
  function automatic logic [CoefW-1:0] scaled_coef(input int shift);
    logic signed [CoefW-1:0] c;
    c = $signed($urandom());
    return c >>> shift;
  endfunction

  // whole calibration and filter chain for one word
  function automatic conc_word_t predict_concentration(input logic [TempW-1:0] t,
      input logic [SwingW-1:0] act, input logic [SwingW-1:0] refs);
    conc_word_t res;
    longint x, y, s;
    longint unsigned v, ip;
    int val, sum, d, out, slot;
    x = longint'(t);
    y = longint'(refs) - longint'(act);
    s = longint'(coef_shadow[REG_TEMP]) * x
      + longint'(coef_shadow[REG_DIFF]) * y
      + longint'(coef_shadow[REG_TEMP_SQ]) * (x * x)
      + longint'(coef_shadow[REG_DIFF_SQ]) * (y * y)
      + longint'(coef_shadow[REG_CROSS]) * (x * y)
      + longint'(coef_shadow[REG_OFFSET]);
    v = (s < 0) ? longint'(-s) : s;
    if (v < (64'(LiftLimit) << FracW)) ip = LiftBase + v / (64'(LiftDiv) << FracW);
    else ip = v >> FracW;
    ip = ip / ScaleDiv;
    if (ip > OutMax) ip = OutMax;
    val = int'(ip);
    // ring average, pass-through during warm-up
    if (fill_shadow < Window - 1) begin
      ring_shadow[fill_shadow] = val[ConcW-1:0];
      fill_shadow++;
      res.full = 1'b0;
    end else begin
      slot = fill_shadow % Window;
      ring_shadow[slot] = val[ConcW-1:0];
      sum = 0;
      for (int i = 0; i < Window; i++) sum += ring_shadow[i];
      val = sum / Window;
      ring_shadow[slot] = val[ConcW-1:0];
      fill_shadow = slot + 1;
      res.full = 1'b1;
    end
    // step limiter
    d = val - limiter_shadow;
    if (d > StepLimit || d < -StepLimit) val = limiter_shadow + d / StepDiv;
    limiter_shadow = val;
    // two-point smoother
    out = (val + smoother_shadow) / 2;
    smoother_shadow = val;
    if (out > OutMax) out = OutMax;
    res.conc = out[ConcW-1:0];
    return res;
  endfunction

  // one word through the input channel
  task automatic send_word(input logic [TempW-1:0] t, input logic [SwingW-1:0] act,
      input logic [SwingW-1:0] refs);
    int gap;
    in_valid        <= 1'b1;
    temperature     <= t;
    active_swing    <= act;
    reference_swing <= refs;
    do @(posedge clk); while (in_stall);
    conc_expected.push_back(predict_concentration(t, act, refs));
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_word();
    logic [TempW-1:0]  t;
    logic [SwingW-1:0] a;
    logic [SwingW-1:0] r;
    t = TempW'($urandom_range(0, 127));
    a = SwingW'($urandom_range(0, 4095));
    r = SwingW'($urandom_range(0, 4095));
    if ($urandom_range(0, 3) == 0)
      send_word(t, a, a ^ SwingW'($urandom_range(0, 15)));
    else
      send_word(t, a, r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (conc_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write: setup, access, then an idle phase
  task automatic write_coef(input int idx, input logic [CoefW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (idx < RegCount) coef_shadow[idx] = value;
    coef_writes++;
  endtask

  task automatic write_all(input logic [CoefW-1:0] t, input logic [CoefW-1:0] d,
      input logic [CoefW-1:0] tsq, input logic [CoefW-1:0] dsq,
      input logic [CoefW-1:0] cr, input logic [CoefW-1:0] off);
    wait_drained();
    write_coef(REG_TEMP, t);
    write_coef(REG_DIFF, d);
    write_coef(REG_TEMP_SQ, tsq);
    write_coef(REG_DIFF_SQ, dsq);
    write_coef(REG_CROSS, cr);
    write_coef(REG_OFFSET, off);
  endtask

  // zero coefficients from reset, field extremes
  task automatic test_reset_values();
    send_word(7'd0, 12'd0, 12'd0);
    send_word(7'd127, 12'd4095, 12'd4095);
    send_word(7'd127, 12'd0, 12'd4095);
    send_word(7'd0, 12'd4095, 12'd0);
  endtask

  // largest and most negative coefficients, saturating values
  task automatic test_extreme_coefs();
    write_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff);
    send_word(7'd127, 12'd0, 12'd4095);
    send_word(7'd127, 12'd4095, 12'd0);
    write_all(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000);
    send_word(7'd127, 12'd4095, 12'd0);
    send_word(7'd0, 12'd0, 12'd0);
    // write beyond the last register is ignored
    wait_drained();
    write_coef(RegBeyond, 32'h12345678);
    send_word(7'd64, 12'd2048, 12'd1024);
  endtask

  // tiny offsets around the lift threshold, then a jump for the limiter
  task automatic test_lift_and_steps();
    write_all(0, 0, 0, 0, 0, 32'd4499 * 65536);
    send_word(7'd10, 12'd100, 12'd100);
    write_all(0, 0, 0, 0, 0, -(32'd4500 * 65536));
    send_word(7'd10, 12'd100, 12'd100);
    write_all(0, 32'sd65536 * 4000, 0, 0, 0, 0);
    // big up and down steps through the limiter and warm-up edge
    for (int i = 0; i < 10; i++) begin
      send_word(7'd25, (i % 2) ? 12'd0 : 12'd4095, (i % 2) ? 12'd4095 : 12'd0);
    end
    send_word(7'd25, 12'd2000, 12'd2001);
    send_word(7'd25, 12'd2000, 12'd2000);
  endtask

  // random settings, from full-range coefficients to small ones
  task automatic test_random_settings();
    int shifts [9] = '{0, 4, 8, 12, 16, 20, 24, 28, 31};
    for (int p = 0; p < 18; p++) begin
      write_all(scaled_coef(shifts[$urandom_range(0, 8)]),
                scaled_coef(shifts[$urandom_range(0, 8)]),
                scaled_coef(shifts[$urandom_range(0, 8)]),
                scaled_coef(shifts[$urandom_range(0, 8)]),
                scaled_coef(shifts[$urandom_range(0, 8)]),
                scaled_coef(shifts[$urandom_range(0, 8)]));
      no_idle = (p % 6 == 3);
      repeat (55) send_random_word();
    end
    no_idle = 1'b0;
  endtask

  // sender waits for each result before the next word
  task automatic test_drained_sender();
    write_all(scaled_coef(16), scaled_coef(20), scaled_coef(24),
              scaled_coef(28), scaled_coef(22), scaled_coef(8));
    repeat (30) begin
      send_random_word();
      wait_drained();
    end
  endtask

  // output channel stall pattern
  always @(posedge clk) begin
    int g;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      g = pick_gap();
      stall_left = g;
      out_stall <= (g != 0);
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    conc_word_t exp_word;
    if (!rst && out_valid && !out_stall) begin
      if (conc_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: concentration=%0d window_full=%0b",
                   concentration, window_full);
      end else begin
        exp_word = conc_expected.pop_front();
        words_checked++;
        if (concentration !== exp_word.conc || window_full !== exp_word.full) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: concentration exp %0d got %0d, window_full exp %0b got %0b",
                     words_checked, exp_word.conc, concentration, exp_word.full,
                     window_full);
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; temperature = '0; active_swing = '0; reference_swing = '0;
    mismatches = 0; words_sent = 0; words_checked = 0; coef_writes = 0;
    no_idle = 1'b0;
    fill_shadow = 0; limiter_shadow = 0; smoother_shadow = 0;
    for (int i = 0; i < RegCount; i++) coef_shadow[i] = '0;
    for (int i = 0; i < Window; i++) ring_shadow[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_extreme_coefs();
    test_lift_and_steps();
    test_random_settings();
    test_drained_sender();

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    $display("sent %0d words, checked %0d, %0d coefficient writes", words_sent,
             words_checked, coef_writes);
    $display("covered lift region, saturation, warm-up, limiter steps and stalls");
    if (mismatches == 0 && conc_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d words outstanding", mismatches,
               conc_expected.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
